// ===== hdl/qcr_pkg.sv =====
// Package: default widths and root kind codes for the quadratic root solver.
package qcr_pkg;

   localparam int COEF_WIDTH_DEF   = 16;
   localparam int RESULT_WIDTH_DEF = 32;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_COMPLEX = 2'd1,
      KIND_DOUBLE  = 2'd2,
      KIND_REAL    = 2'd3
   } root_kind_type;

endpackage

// ===== hdl/quadratic_complex_roots.sv =====
// Top level of the pipelined quadratic root solver.
//
//  channel | ports                                    | direction
//  req     | req_valid, req_stall, req_coef_a/b/c     | in
//  rsp     | rsp_valid, rsp_stall, rsp_root_kind,     | out
//          | rsp_first_value, rsp_second_value        |
//
// One transfer can enter every cycle while the pipe is not stalled. The pipe is built from
// two front stages (products, discriminant), one stage per root bit, one numerator stage,
// one stage per quotient bit in the two parallel dividers, then the output register.
// Reset clears only valid bits; payload registers are not reset.
// A stall on rsp freezes the whole pipe (shared advance) unless the output register is empty,
// so req_stall follows rsp_stall only when the output holds a result; nothing is lost or
// repeated.
module quadratic_complex_roots
   import qcr_pkg::*;
#(
   parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
   parameter int RESULT_WIDTH = RESULT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [COEF_WIDTH-1:0]   req_coef_a,
   input  logic signed [COEF_WIDTH-1:0]   req_coef_b,
   input  logic signed [COEF_WIDTH-1:0]   req_coef_c,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_root_kind,
   output logic signed [RESULT_WIDTH-1:0] rsp_first_value,
   output logic signed [RESULT_WIDTH-1:0] rsp_second_value
);

   localparam int SQ_FRAC = 30 - COEF_WIDTH;
   localparam int DW      = 2 * COEF_WIDTH + 3;        // signed discriminant width
   localparam int SQ_IN   = 2 * (DW - 1 + 2 * SQ_FRAC) / 2 * 1 + ((DW - 1) % 2);
   localparam int SQ_W    = SQ_IN + (SQ_IN % 2);       // even radicand width
   localparam int RT_W    = SQ_W / 2;
   localparam int NUM_W   = RT_W + 2;                  // |nb +- s| fits here
   localparam int DEN_W   = COEF_WIDTH + 1 + SQ_FRAC;  // (2|a|) << SQ_FRAC
   localparam int QN_W    = NUM_W + 16 + 1;            // (un<<16) + d/2

   // advance the whole pipe unless a held result is stalled
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // stage 1: products, formed at full product width before extension
   logic                           s1_v_ff;
   logic signed [COEF_WIDTH-1:0]   s1_a_ff, s1_b_ff;
   logic signed [DW-1:0]           s1_bb_ff, s1_ac4_ff;
   logic signed [2*COEF_WIDTH-1:0] bb_prod, ac_prod;
   assign bb_prod = req_coef_b * req_coef_b;
   assign ac_prod = req_coef_a * req_coef_c;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= req_valid;
      end
      if (advance) begin
         s1_a_ff   <= req_coef_a;
         s1_b_ff   <= req_coef_b;
         s1_bb_ff  <= DW'(bb_prod);
         s1_ac4_ff <= DW'(ac_prod) <<< 2;
      end
   end

   // stage 2: discriminant and kind
   logic                         s2_v_ff;
   logic signed [COEF_WIDTH-1:0] s2_a_ff, s2_b_ff;
   logic [1:0]                   s2_kind_ff;
   logic [DW-1:0]                s2_mag_ff;
   logic signed [DW-1:0]         delta_in;
   assign delta_in = s1_bb_ff - s1_ac4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (advance) begin
         s2_v_ff <= s1_v_ff;
      end
      if (advance) begin
         s2_a_ff   <= s1_a_ff;
         s2_b_ff   <= s1_b_ff;
         s2_mag_ff <= delta_in[DW-1] ? DW'(-delta_in) : delta_in;
         if (s1_a_ff == '0) begin
            s2_kind_ff <= KIND_NONE;
         end else if (delta_in[DW-1]) begin
            s2_kind_ff <= KIND_COMPLEX;
         end else if (delta_in == '0) begin
            s2_kind_ff <= KIND_DOUBLE;
         end else begin
            s2_kind_ff <= KIND_REAL;
         end
      end
   end

   // square root of |delta| << 2*SQ_FRAC; tag carries kind, a, b
   localparam int ST_W = 2 + 2 * COEF_WIDTH;
   logic [SQ_W-1:0] sq_in;
   assign sq_in = SQ_W'({s2_mag_ff, {(2*SQ_FRAC){1'b0}}});
   logic            rt_v;
   logic [RT_W-1:0] rt_root;
   logic [ST_W-1:0] rt_tag;
   qcr_sqrt #(.IN_WIDTH(SQ_W), .TAG_WIDTH(ST_W)) u_sqrt (
      .clock, .reset, .advance,
      .in_valid(s2_v_ff), .in_value(sq_in),
      .in_tag({s2_kind_ff, s2_a_ff, s2_b_ff}),
      .out_valid(rt_v), .out_root(rt_root), .out_tag(rt_tag)
   );

   logic [1:0]                   rt_kind;
   logic signed [COEF_WIDTH-1:0] rt_a, rt_b;
   assign {rt_kind, rt_a, rt_b} = rt_tag;

   // stage 3: numerators and divisor
   logic                  s3_v_ff;
   logic [1:0]            s3_kind_ff;
   logic                  s3_n1neg_ff, s3_n2neg_ff, s3_aneg_ff;
   logic [QN_W-1:0]       s3_n1_ff, s3_n2_ff;
   logic [DEN_W-1:0]      s3_d_ff;
   logic signed [NUM_W:0] nb, sr, n1, n2;
   logic [NUM_W:0]        m1, m2;
   logic [DEN_W-1:0]      dd;
   always_comb begin
      nb = (NUM_W+1)'(-(signed'({{(NUM_W+1-COEF_WIDTH){rt_b[COEF_WIDTH-1]}}, rt_b}) <<< SQ_FRAC));
      sr = signed'({1'b0, (NUM_W)'(rt_root)});
      if (rt_kind == KIND_REAL) begin
         n1 = nb + sr;
         n2 = nb - sr;
      end else if (rt_kind == KIND_COMPLEX) begin
         n1 = nb;
         n2 = sr;
      end else begin
         n1 = nb;
         n2 = nb;
      end
      m1 = n1[NUM_W] ? (NUM_W+1)'(-n1) : n1;
      m2 = n2[NUM_W] ? (NUM_W+1)'(-n2) : n2;
      dd = DEN_W'({(rt_a[COEF_WIDTH-1] ? COEF_WIDTH'(-rt_a) : rt_a), 1'b0}) << SQ_FRAC;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (advance) begin
         s3_v_ff <= rt_v;
      end
      if (advance) begin
         s3_kind_ff  <= rt_kind;
         s3_n1neg_ff <= n1[NUM_W];
         s3_n2neg_ff <= n2[NUM_W];
         s3_aneg_ff  <= rt_a[COEF_WIDTH-1];
         s3_d_ff     <= (dd == '0) ? DEN_W'(1) : dd;
         s3_n1_ff    <= QN_W'({m1, 16'h0000}) + QN_W'(dd >> 1);
         s3_n2_ff    <= QN_W'({m2, 16'h0000}) + QN_W'(dd >> 1);
      end
   end

   // kind and signs of the first value ride with divider 1, the second sign with divider 2
   logic            q1_v, q2_v;
   logic [QN_W-1:0] q1, q2;
   logic [3:0]      q1_tag;
   logic            q2_tag;
   qcr_div #(.NUM_WIDTH(QN_W), .DEN_WIDTH(DEN_W), .TAG_WIDTH(4)) u_div1 (
      .clock, .reset, .advance,
      .in_valid(s3_v_ff), .in_num(s3_n1_ff), .in_den(s3_d_ff),
      .in_tag({s3_kind_ff, s3_n1neg_ff, s3_aneg_ff}),
      .out_valid(q1_v), .out_quo(q1), .out_tag(q1_tag)
   );
   qcr_div #(.NUM_WIDTH(QN_W), .DEN_WIDTH(DEN_W), .TAG_WIDTH(1)) u_div2 (
      .clock, .reset, .advance,
      .in_valid(s3_v_ff), .in_num(s3_n2_ff), .in_den(s3_d_ff),
      .in_tag(s3_n2neg_ff),
      .out_valid(q2_v), .out_quo(q2), .out_tag(q2_tag)
   );

   // saturate one signed magnitude to RESULT_WIDTH
   function automatic logic [RESULT_WIDTH-1:0] sat_val(input logic [QN_W-1:0] mag,
                                                       input logic neg);
      logic [QN_W:0] hi;
      logic [QN_W:0] m;
      hi = (QN_W+1)'({1'b0, {(RESULT_WIDTH-1){1'b1}}});
      m  = {1'b0, mag};
      if (neg) begin
         if (m > hi) begin
            sat_val = {1'b1, {(RESULT_WIDTH-1){1'b0}}};
         end else begin
            sat_val = RESULT_WIDTH'(-m);
         end
      end else begin
         sat_val = (m > hi) ? {1'b0, {(RESULT_WIDTH-1){1'b1}}} : RESULT_WIDTH'(m);
      end
   endfunction

   logic [1:0]              o_kind;
   logic                    o_n1neg, o_aneg;
   logic [RESULT_WIDTH-1:0] v1_in, v2_in;
   assign {o_kind, o_n1neg, o_aneg} = q1_tag;
   always_comb begin
      v1_in = sat_val(q1, o_n1neg ^ o_aneg);
      v2_in = sat_val(q2, q2_tag ^ o_aneg);
      if (o_kind == KIND_NONE) begin
         v1_in = '0;
         v2_in = '0;
      end else if (o_kind == KIND_DOUBLE) begin
         v2_in = v1_in;
      end
   end

   // output register; hold while stalled
   logic                    out_v_ff;
   logic [1:0]              out_kind_ff;
   logic [RESULT_WIDTH-1:0] out_v1_ff, out_v2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (advance) begin
         out_v_ff <= q1_v && q2_v;
      end
      if (advance) begin
         out_kind_ff <= o_kind;
         out_v1_ff   <= v1_in;
         out_v2_ff   <= v2_in;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_root_kind    = out_kind_ff;
   assign rsp_first_value  = out_v1_ff;
   assign rsp_second_value = out_v2_ff;

endmodule

// ===== hdl/qcr_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module qcr_sqrt
   import qcr_pkg::*;
#(
   parameter int IN_WIDTH = 64,
   parameter int TAG_WIDTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [IN_WIDTH-1:0]     in_value,
   input  logic [TAG_WIDTH-1:0]    in_tag,
   output logic                    out_valid,
   output logic [IN_WIDTH/2-1:0]   out_root,
   output logic [TAG_WIDTH-1:0]    out_tag
);

   localparam int RW = IN_WIDTH / 2;

   logic               vld_s [RW+1];
   logic [IN_WIDTH-1:0] rem_s [RW+1];
   logic [RW-1:0]      root_s [RW+1];
   logic [IN_WIDTH-1:0] val_s [RW+1];
   logic [TAG_WIDTH-1:0] tag_s [RW+1];

   always_comb begin
      vld_s[0]  = in_valid;
      rem_s[0]  = '0;
      root_s[0] = '0;
      val_s[0]  = in_value;
      tag_s[0]  = in_tag;
   end

   for (genvar i = 0; i < RW; i++) begin : g_step
      logic [IN_WIDTH-1:0] rem_in;
      logic [IN_WIDTH-1:0] trial;
      logic [RW-1:0]       root_in;
      always_comb begin
         rem_in = {rem_s[i][IN_WIDTH-3:0], val_s[i][IN_WIDTH-1 -: 2]};
         trial  = {{(IN_WIDTH-RW-2){1'b0}}, root_s[i], 2'b01};
         if (rem_in >= trial) begin
            root_in = {root_s[i][RW-2:0], 1'b1};
            rem_in  = rem_in - trial;
         end else begin
            root_in = {root_s[i][RW-2:0], 1'b0};
         end
      end
      logic                 v_ff;
      logic [IN_WIDTH-1:0]  r_ff, x_ff;
      logic [RW-1:0]        s_ff;
      logic [TAG_WIDTH-1:0] t_ff;
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (advance) begin
            v_ff <= vld_s[i];
         end
         if (advance) begin
            r_ff <= rem_in;
            s_ff <= root_in;
            x_ff <= {val_s[i][IN_WIDTH-3:0], 2'b00};
            t_ff <= tag_s[i];
         end
      end
      always_comb begin
         vld_s[i+1]  = v_ff;
         rem_s[i+1]  = r_ff;
         root_s[i+1] = s_ff;
         val_s[i+1]  = x_ff;
         tag_s[i+1]  = t_ff;
      end
   end

   assign out_valid = vld_s[RW];
   assign out_root  = root_s[RW];
   assign out_tag   = tag_s[RW];

endmodule

// ===== hdl/qcr_div.sv =====
// Pipelined restoring divider on magnitudes, one quotient bit per stage; the caller adds den/2 to round half up.
module qcr_div
   import qcr_pkg::*;
#(
   parameter int NUM_WIDTH = 64,
   parameter int DEN_WIDTH = 32,
   parameter int TAG_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [NUM_WIDTH-1:0]  in_num,
   input  logic [DEN_WIDTH-1:0]  in_den,
   input  logic [TAG_WIDTH-1:0]  in_tag,
   output logic                  out_valid,
   output logic [NUM_WIDTH-1:0]  out_quo,
   output logic [TAG_WIDTH-1:0]  out_tag
);

   // numerator already carries +den/2; quotient = floor(num/den)
   localparam int RW = DEN_WIDTH + 1;

   logic                 v_s [NUM_WIDTH+1];
   logic [RW-1:0]        r_s [NUM_WIDTH+1];
   logic [NUM_WIDTH-1:0] n_s [NUM_WIDTH+1];
   logic [DEN_WIDTH-1:0] d_s [NUM_WIDTH+1];
   logic [TAG_WIDTH-1:0] t_s [NUM_WIDTH+1];

   always_comb begin
      v_s[0] = in_valid;
      r_s[0] = '0;
      n_s[0] = in_num;
      d_s[0] = in_den;
      t_s[0] = in_tag;
   end

   for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_step
      logic [RW-1:0]        rem_in;
      logic                 qbit;
      always_comb begin
         rem_in = {r_s[i][RW-2:0], n_s[i][NUM_WIDTH-1]};
         qbit   = (rem_in >= {1'b0, d_s[i]});
         if (qbit) begin
            rem_in = rem_in - {1'b0, d_s[i]};
         end
      end
      logic                 v_ff;
      logic [RW-1:0]        r_ff;
      logic [NUM_WIDTH-1:0] n_ff;
      logic [DEN_WIDTH-1:0] d_ff;
      logic [TAG_WIDTH-1:0] t_ff;
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (advance) begin
            v_ff <= v_s[i];
         end
         if (advance) begin
            r_ff <= rem_in;
            n_ff <= {n_s[i][NUM_WIDTH-2:0], qbit};
            d_ff <= d_s[i];
            t_ff <= t_s[i];
         end
      end
      always_comb begin
         v_s[i+1] = v_ff;
         r_s[i+1] = r_ff;
         n_s[i+1] = n_ff;
         d_s[i+1] = d_ff;
         t_s[i+1] = t_ff;
      end
   end

   assign out_valid = v_s[NUM_WIDTH];
   assign out_quo   = n_s[NUM_WIDTH];
   assign out_tag   = t_s[NUM_WIDTH];

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the pipelined quadratic root solver.
module testbench
   import qcr_pkg::*;
();

   localparam int CW        = COEF_WIDTH_DEF;
   localparam int RW        = RESULT_WIDTH_DEF;
   localparam int SQF       = 30 - CW;        // extra fraction bits of the root
   localparam int IDLE_PCT  = 20;
   localparam int HOLD_LEN  = 400;            // long receiver hold-off, in cycles
   localparam int DRAIN_LEN = 200;            // covers the pipeline depth
   localparam int DOG_LIMIT = 5000;           // cycles without any transfer

   typedef struct packed {
      root_kind_type      kind;
      logic signed [RW-1:0] first;
      logic signed [RW-1:0] second;
   } roots_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [CW-1:0] req_coef_a;
   logic signed [CW-1:0] req_coef_b;
   logic signed [CW-1:0] req_coef_c;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_root_kind;
   logic signed [RW-1:0] rsp_first_value;
   logic signed [RW-1:0] rsp_second_value;

   roots_type pending_roots[$];
   int     error_count = 0;
   bit     send_idle   = 1;   // sender inserts random gaps
   bit     recv_idle   = 1;   // receiver inserts random stalls
   int     hold_left   = 0;   // cycles left in a forced receiver hold-off
   int     dog_count   = 0;

   quadratic_complex_roots DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_coef_a       (req_coef_a),
      .req_coef_b       (req_coef_b),
      .req_coef_c       (req_coef_c),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_root_kind    (rsp_root_kind),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Integer square root, floor, by the digit-by-digit method.
   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Quotient num/(2a) to Q16.16, rounded half away from zero, then saturated.
   function automatic logic signed [RW-1:0] half_quotient(longint num, longint a);
      longint unsigned un;
      longint unsigned ua;
      longint unsigned d;
      longint          v;
      longint          hi;
      un = (num < 0) ? -num : num;
      ua = (a < 0) ? -a : a;
      d  = (2 * ua) << SQF;
      v  = ((un << 16) + d / 2) / d;
      hi = (64'sd1 <<< (RW - 1)) - 1;
      if ((num < 0) != (a < 0)) v = -v;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return v[RW-1:0];
   endfunction

   function automatic roots_type solve_roots(logic signed [CW-1:0] ca,
                                             logic signed [CW-1:0] cb,
                                             logic signed [CW-1:0] cc);
      roots_type r;
      longint a;
      longint b;
      longint c;
      longint delta;
      longint nb;
      longint s;
      a = ca;
      b = cb;
      c = cc;
      r = '0;
      r.kind = KIND_NONE;
      if (a != 0) begin
         delta = b * b - 4 * a * c;
         nb    = -b * (64'sd1 <<< SQF);
         if (delta < 0) begin
            s        = int_sqrt(longint'(-delta) << (2 * SQF));
            r.kind   = KIND_COMPLEX;
            r.first  = half_quotient(nb, a);
            r.second = half_quotient(s, a);
         end else if (delta == 0) begin
            r.kind   = KIND_DOUBLE;
            r.first  = half_quotient(nb, a);
            r.second = r.first;
         end else begin
            s        = int_sqrt(longint'(delta) << (2 * SQF));
            r.kind   = KIND_REAL;
            r.first  = half_quotient(nb + s, a);
            r.second = half_quotient(nb - s, a);
         end
      end
      return r;
   endfunction

   // Offer one coefficient set and hold it until the transfer happens.
   task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                             logic signed [CW-1:0] c);
      while (send_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_roots.push_back(solve_roots(a, b, c));
   endtask

   task automatic send_random;
      send_coefs(CW'($urandom), CW'($urandom), CW'($urandom));
   endtask

   // Receiver: random stalls, or a solid hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= recv_idle && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Compare each result transfer with the oldest prediction.
   always @(posedge clock) begin
      roots_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_roots.size() == 0) begin
            $error("unexpected result: kind %0d first %0d second %0d",
                   rsp_root_kind, rsp_first_value, rsp_second_value);
            error_count++;
         end else begin
            want = pending_roots.pop_front();
            if (rsp_root_kind !== want.kind) begin
               $error("root_kind: expected %0d, actual %0d", want.kind, rsp_root_kind);
               error_count++;
            end
            if (rsp_first_value !== want.first) begin
               $error("first_value: expected %0d, actual %0d", want.first, rsp_first_value);
               error_count++;
            end
            if (rsp_second_value !== want.second) begin
               $error("second_value: expected %0d, actual %0d", want.second,
                      rsp_second_value);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         dog_count <= 0;
      end else begin
         dog_count <= dog_count + 1;
         if (dog_count >= DOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Extremes of every field and each root kind, including saturation.
   task automatic test_directed;
      send_coefs(16'sd0, 16'sd1234, -16'sd77);           // a zero
      send_coefs(16'sd0, 16'sh7fff, 16'sh8000);
      send_coefs(16'sd256, 16'sd0, 16'sd256);            // x^2+1: complex
      send_coefs(-16'sd256, 16'sd512, -16'sd1024);       // complex, a negative
      send_coefs(16'sd256, 16'sd512, 16'sd256);          // double root
      send_coefs(-16'sd768, 16'sd1536, -16'sd768);       // double root, a negative
      send_coefs(16'sd256, 16'sd0, -16'sd1024);          // two real roots
      send_coefs(16'sd256, -16'sd768, 16'sd512);
      send_coefs(16'sd1, 16'sh7fff, 16'sd0);             // tiny a: a root of -32767, just in range
      send_coefs(16'sd1, 16'sh8000, 16'sd0);
      send_coefs(-16'sd1, 16'sh7fff, 16'sh7fff);
      send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
      send_coefs(16'sh8000, 16'sh7fff, 16'sh7fff);
      send_coefs(16'sh7fff, 16'sh8000, 16'sh8000);
      send_coefs(16'sd1, 16'sd0, 16'sd1);
      send_coefs(-16'sd1, 16'sd0, 16'sd1);
      send_coefs(16'sd1, 16'sd2, 16'sd1);                // double, tiny values
      send_coefs(16'shffff, 16'shffff, 16'shffff);
   endtask

   // Random sets, biased so every root kind turns up often.
   task automatic test_random(int count);
      int k;
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(9);
         k   = $urandom_range(1, 180);
         if ($urandom_range(1)) k = -k;
         case (sel)
            0: begin
               send_coefs(16'sd0, CW'($urandom), CW'($urandom));
            end
            1: begin
               send_coefs(16'(k), 16'(2 * k), 16'(k));   // double root
            end
            2: begin
               send_coefs(CW'($urandom_range(1, 255)), CW'($urandom), CW'($urandom));
            end
            default: begin
               send_random();
            end
         endcase
      end
   endtask

   // Hold the receiver off while the sender keeps offering, to fill the pipe.
   task automatic test_backpressure;
      hold_left <= HOLD_LEN;
      for (int i = 0; i < 60; i++) send_random();
   endtask

   // A long stretch with neither side idling.
   task automatic test_full_rate;
      send_idle = 0;
      recv_idle = 0;
      test_random(120);
      send_idle = 1;
      recv_idle = 1;
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_coef_a = '0;
      req_coef_b = '0;
      req_coef_c = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(200);
      test_backpressure();
      test_full_rate();
      test_random(120);

      req_valid <= 1'b0;
      while (pending_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_LEN) @(posedge clock);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/qcr_pkg.sv
hdl/qcr_sqrt.sv
hdl/qcr_div.sv
hdl/quadratic_complex_roots.sv
bench/testbench.sv
